// File: hdl/ili_pkg.sv
// ----------------------------------------------------------------------------
// Indexed list package
// Shared constants, operation and status codes, and the cell command type.
// ----------------------------------------------------------------------------
package ili_pkg;

    // List size and derived widths.
    localparam int CAPACITY  = 64;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = 7;
    localparam int VAL_W     = 32;
    localparam int FUNC_W    = 3;
    localparam int STAT_W    = 2;

    // Read selection is split into groups of up to eight cells.
    localparam int SUB_W     = (IDX_W < 3) ? IDX_W : 3;
    localparam int GRP_SIZE  = 1 << SUB_W;
    localparam int NUM_GRP   = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GRP_W     = (IDX_W > SUB_W) ? (IDX_W - SUB_W) : 1;

    // Stream word widths, padded to whole bytes.
    localparam int IN_BITS   = FUNC_W + CNT_W + VAL_W;
    localparam int IN_DW     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = VAL_W + STAT_W + CNT_W;
    localparam int OUT_DW    = ((OUT_BITS + 7) / 8) * 8;

    // Operation codes.
    localparam logic [FUNC_W-1:0] OP_READ = 3'd0;
    localparam logic [FUNC_W-1:0] OP_HEAD = 3'd1;
    localparam logic [FUNC_W-1:0] OP_TAIL = 3'd2;
    localparam logic [FUNC_W-1:0] OP_AT   = 3'd3;
    localparam logic [FUNC_W-1:0] OP_DEL  = 3'd4;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [CNT_W-1:0] pos;
        logic [VAL_W-1:0] value;
    } cell_cmd_t;

endpackage

// File: hdl/indexed_list_insert_delete.sv
// ----------------------------------------------------------------------------
// Indexed list with insert and delete by position
// Top level: request decode, row of cells, read tree and result register.
// ----------------------------------------------------------------------------
// The list sits in a row of CAPACITY cells, one entry per cell. An insert or
// delete is broadcast to every cell, and each cell loads the new value, takes
// its lower or upper neighbour's entry, or holds, all in the cycle the request
// is accepted. A read goes through a two-level registered select tree: the
// request is registered into the group registers when accepted, and the
// picked value then into the result word register. A new request is taken
// only while no request is being worked on and the result word has left or
// is leaving. Requests that are rejected leave the list unchanged.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata: func[2:0], position[9:3], item_value[41:10], zero padding above
    input  logic [ili_pkg::IN_DW-1:0]     s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: read_value[31:0], status[33:32], entry_count[40:34], zero padding
    output logic [ili_pkg::OUT_DW-1:0]    m_tdata
);
    import ili_pkg::*;

    logic [FUNC_W-1:0] in_func;
    logic [CNT_W-1:0]  in_pos;
    logic [VAL_W-1:0]  in_value;
    logic              accept;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              busy_reg;
    logic              out_valid_reg;
    logic              out_valid_next;

    logic              rd_ok_reg;
    logic              rd_bad_reg;
    logic [STAT_W-1:0] status_reg;
    logic              rd_ok;
    logic              rd_bad;
    logic [STAT_W-1:0] status;

    logic [VAL_W-1:0]  out_value_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic [CNT_W-1:0]  out_count_reg;

    cell_cmd_t         cmd;
    logic              full;
    logic [VAL_W-1:0]  entries [CAPACITY];
    logic [VAL_W-1:0]  sel_value;

    // Unpack the request word.
    assign in_func  = s_tdata[FUNC_W-1:0];
    assign in_pos   = s_tdata[FUNC_W +: CNT_W];
    assign in_value = s_tdata[FUNC_W+CNT_W +: VAL_W];

    assign s_tready = !busy_reg && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(CAPACITY));

    // Decode the request against the present count.
    always_comb
    begin
        cmd        = '0;
        cmd.value  = in_value;
        rd_ok      = 1'b0;
        rd_bad     = 1'b0;
        status     = ST_OK;
        count_next = count_reg;
        unique case (in_func) inside
            OP_READ:
            begin
                if (in_pos < count_reg)
                begin
                    rd_ok = 1'b1;
                end
                else
                begin
                    rd_bad = 1'b1;
                    status = ST_RANGE;
                end
            end
            OP_HEAD, OP_TAIL:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    cmd.ins    = accept;
                    cmd.pos    = (in_func == OP_HEAD) ? '0 : count_reg;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_AT:
            begin
                if (in_pos > count_reg)
                begin
                    status = ST_RANGE;
                end
                else if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    cmd.ins    = accept;
                    cmd.pos    = in_pos;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_DEL:
            begin
                if (in_pos >= count_reg)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    cmd.del    = accept;
                    cmd.pos    = in_pos;
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    // Row of cells.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VAL_W-1:0] lower_entry;
        logic [VAL_W-1:0] upper_entry;

        if (i == 0)
        begin : g_first
            assign lower_entry = '0;
        end
        else
        begin : g_lower
            assign lower_entry = entries[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign upper_entry = '0;
        end
        else
        begin : g_upper
            assign upper_entry = entries[i+1];
        end

        ili_cell u_cell (
            .clk         (clk),
            .cell_idx    (IDX_W'(i)),
            .cmd         (cmd),
            .lower_entry (lower_entry),
            .upper_entry (upper_entry),
            .entry       (entries[i])
        );
    end

    // Read tree captures the row before any update lands.
    ili_sel u_sel (
        .clk       (clk),
        .capture   (accept),
        .entries   (entries),
        .sub_idx   (in_pos[SUB_W-1:0]),
        .grp_idx   (GRP_W'(in_pos >> SUB_W)),
        .sel_value (sel_value)
    );

    // Control state.
    assign out_valid_next = busy_reg ? 1'b1 : (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            busy_reg      <= accept;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request outcome held for the working cycle.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_ok_reg  <= rd_ok;
            rd_bad_reg <= rd_bad;
            status_reg <= status;
        end
    end

    // Result word register.
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            out_value_reg  <= rd_ok_reg  ? sel_value :
                              rd_bad_reg ? '1 : '0;
            out_status_reg <= status_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DW'({out_count_reg, out_status_reg, out_value_reg});

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // An accepted request is followed by a working cycle.
    a_busy_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("no working cycle after an accepted request");

    // A result word only appears after a working cycle.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(busy_reg))
        else $error("result word without a request");

    // The reported count is the count held by the list.
    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_count_reg == count_reg)
        else $error("reported count differs from held count");

endmodule

// File: hdl/ili_cell.sv
// ----------------------------------------------------------------------------
// Indexed list cell
// Holds one entry; loads, takes a neighbour's entry or holds on each command.
// ----------------------------------------------------------------------------
module ili_cell (
    input  logic                      clk,
    input  logic [ili_pkg::IDX_W-1:0] cell_idx,
    input  ili_pkg::cell_cmd_t        cmd,
    input  logic [ili_pkg::VAL_W-1:0] lower_entry,
    input  logic [ili_pkg::VAL_W-1:0] upper_entry,
    output logic [ili_pkg::VAL_W-1:0] entry
);
    import ili_pkg::*;

    logic [VAL_W-1:0] entry_reg;
    logic [VAL_W-1:0] entry_next;
    logic [CNT_W-1:0] idx_ext;

    assign idx_ext = CNT_W'(cell_idx);

    // Insert moves entries above the position up; delete pulls them down.
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins && idx_ext == cmd.pos)
        begin
            entry_next = cmd.value;
        end
        else if (cmd.ins && idx_ext > cmd.pos)
        begin
            entry_next = lower_entry;
        end
        else if (cmd.del && idx_ext >= cmd.pos)
        begin
            entry_next = upper_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// File: hdl/ili_sel.sv
// ----------------------------------------------------------------------------
// Indexed list read select
// Two-level read tree: a registered pick within each group, then a group pick.
// ----------------------------------------------------------------------------
module ili_sel (
    input  logic                      clk,
    input  logic                      capture,
    input  logic [ili_pkg::VAL_W-1:0] entries [ili_pkg::CAPACITY],
    input  logic [ili_pkg::SUB_W-1:0] sub_idx,
    input  logic [ili_pkg::GRP_W-1:0] grp_idx,
    output logic [ili_pkg::VAL_W-1:0] sel_value
);
    import ili_pkg::*;

    logic [VAL_W-1:0] padded   [NUM_GRP*GRP_SIZE];
    logic [VAL_W-1:0] grp_next [NUM_GRP];
    logic [VAL_W-1:0] grp_reg  [NUM_GRP];
    logic [GRP_W-1:0] grp_idx_reg;

    // Pad the row to whole groups.
    always_comb
    begin
        for (int i = 0; i < NUM_GRP * GRP_SIZE; i++)
        begin
            padded[i] = (i < CAPACITY) ? entries[i] : '0;
        end
    end

    // First level: each group picks its member at the low index bits.
    always_comb
    begin
        for (int g = 0; g < NUM_GRP; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < GRP_SIZE; k++)
            begin
                if (sub_idx == SUB_W'(k))
                begin
                    grp_next[g] = padded[g*GRP_SIZE + k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            grp_reg     <= grp_next;
            grp_idx_reg <= grp_idx;
        end
    end

    // Second level: pick the group.
    always_comb
    begin
        sel_value = '0;
        for (int g = 0; g < NUM_GRP; g++)
        begin
            if (grp_idx_reg == GRP_W'(g))
            begin
                sel_value = grp_reg[g];
            end
        end
    end

endmodule

// File: dv/tb_indexed_list_insert_delete.sv
// ----------------------------------------------------------------------------
// Indexed list testbench
// Drives requests into the indexed list over the input stream and checks
// every result word against a positional model of the list in the bench
// or a hand-typed result. A short table of directed requests comes first,
// then random traffic: filling the list, emptying it, mixing operations.
// ----------------------------------------------------------------------------
module tb_indexed_list_insert_delete;
    timeunit 1ns;
    timeprecision 1ps;

    import ili_pkg::*;

    // Spare function codes that the block must ignore.
    localparam logic [FUNC_W-1:0] OP_UNUSED_A = 3'd5;
    localparam logic [FUNC_W-1:0] OP_UNUSED_B = 3'd6;
    localparam logic [FUNC_W-1:0] OP_UNUSED_C = 3'd7;

    localparam int DIR_ROWS       = 24;
    localparam int RAND_ITEMS     = 400;
    localparam int QUIET_ITEMS    = 60;
    localparam int WATCHDOG_LIMIT = 1000;

    // One result word, split into its fields.
    typedef struct packed {
        logic [VAL_W-1:0]  rd;
        logic [STAT_W-1:0] st;
        logic [CNT_W-1:0]  cnt;
    } list_result_t;

    // One row of the directed table; typed marks a result written out by hand.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CNT_W-1:0]  pos;
        logic [VAL_W-1:0]  val;
        logic              typed;
        logic [VAL_W-1:0]  rd;
        logic [STAT_W-1:0] st;
        logic [CNT_W-1:0]  cnt;
    } dir_row_t;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    // s_tdata: func[2:0], position[9:3], item_value[41:10], zero padding above
    logic [IN_DW-1:0]  s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    // m_tdata: read_value[31:0], status[33:32], entry_count[40:34], zero padding
    logic [OUT_DW-1:0] m_tdata;

    // Hand-written expectation travelling alongside the word being offered.
    logic              drv_typed = 1'b0;
    list_result_t      drv_exp   = '0;

    // Bench copy of the list and the results still owed by the block.
    logic [VAL_W-1:0]  list_mem [CAPACITY];
    int                list_len     = 0;
    list_result_t      awaited_results [$];
    int                errors       = 0;
    int                idle_cycles  = 0;
    int                stall_left   = 0;
    bit                tx_idle_en   = 1'b1;
    bit                rx_idle_en   = 1'b1;

    // Directed requests: empty list, extremes of value and position, every
    // operation, append through insert-at, unused codes and rejections.
    dir_row_t dir_tab [DIR_ROWS] = '{
        '{OP_READ,     7'd0,   32'h0000_0000, 1'b1, 32'hFFFF_FFFF, ST_RANGE, 7'd0},
        '{OP_DEL,      7'd0,   32'h0000_0000, 1'b1, 32'h0000_0000, ST_RANGE, 7'd0},
        '{OP_AT,       7'd1,   32'h0000_0005, 1'b1, 32'h0000_0000, ST_RANGE, 7'd0},
        '{OP_READ,     7'd64,  32'h0000_0000, 1'b1, 32'hFFFF_FFFF, ST_RANGE, 7'd0},
        '{OP_AT,       7'd0,   32'h7FFF_FFFF, 1'b1, 32'h0000_0000, ST_OK,    7'd1},
        '{OP_HEAD,     7'd127, 32'h8000_0000, 1'b1, 32'h0000_0000, ST_OK,    7'd2},
        '{OP_TAIL,     7'd64,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_OK,    7'd3},
        '{OP_READ,     7'd0,   32'h0000_0000, 1'b1, 32'h8000_0000, ST_OK,    7'd3},
        '{OP_READ,     7'd1,   32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF, ST_OK,    7'd3},
        '{OP_READ,     7'd2,   32'h0000_0000, 1'b1, 32'hFFFF_FFFF, ST_OK,    7'd3},
        '{OP_READ,     7'd3,   32'h0000_0000, 1'b1, 32'hFFFF_FFFF, ST_RANGE, 7'd3},
        '{OP_AT,       7'd3,   32'h1234_5678, 1'b0, 32'h0,         ST_OK,    7'd0},
        '{OP_READ,     7'd3,   32'h0000_0000, 1'b0, 32'h0,         ST_OK,    7'd0},
        '{OP_AT,       7'd1,   32'hA5A5_A5A5, 1'b0, 32'h0,         ST_OK,    7'd0},
        '{OP_READ,     7'd1,   32'h0000_0000, 1'b0, 32'h0,         ST_OK,    7'd0},
        '{OP_READ,     7'd2,   32'h0000_0000, 1'b0, 32'h0,         ST_OK,    7'd0},
        '{OP_UNUSED_A, 7'd127, 32'hDEAD_BEEF, 1'b0, 32'h0,         ST_OK,    7'd0},
        '{OP_UNUSED_B, 7'd0,   32'hFFFF_FFFF, 1'b0, 32'h0,         ST_OK,    7'd0},
        '{OP_UNUSED_C, 7'd64,  32'h0000_0000, 1'b0, 32'h0,         ST_OK,    7'd0},
        '{OP_DEL,      7'd5,   32'h0000_0000, 1'b0, 32'h0,         ST_OK,    7'd0},
        '{OP_DEL,      7'd0,   32'h0000_0000, 1'b0, 32'h0,         ST_OK,    7'd0},
        '{OP_DEL,      7'd3,   32'h0000_0000, 1'b0, 32'h0,         ST_OK,    7'd0},
        '{OP_READ,     7'd127, 32'h0000_0000, 1'b0, 32'h0,         ST_OK,    7'd0},
        '{OP_AT,       7'd127, 32'h0000_0001, 1'b0, 32'h0,         ST_OK,    7'd0}
    };

    indexed_list_insert_delete DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock, 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one request to the bench list and returns the result it owes.
    function automatic list_result_t apply_list_request(input logic [FUNC_W-1:0] f,
                                                         input logic [CNT_W-1:0]  p,
                                                         input logic [VAL_W-1:0]  v);
        list_result_t res;
        int           ins_at;
        int           i;
        res    = '0;
        ins_at = -1;
        case (f)
            OP_READ:
            begin
                if (int'(p) < list_len)
                    res.rd = list_mem[p];
                else
                begin
                    res.rd = '1;
                    res.st = ST_RANGE;
                end
            end
            OP_HEAD:
                if (list_len >= CAPACITY) res.st = ST_FULL; else ins_at = 0;
            OP_TAIL:
                if (list_len >= CAPACITY) res.st = ST_FULL; else ins_at = list_len;
            OP_AT:
            begin
                // The position check takes precedence over the full check.
                if (int'(p) > list_len)
                    res.st = ST_RANGE;
                else if (list_len >= CAPACITY)
                    res.st = ST_FULL;
                else
                    ins_at = int'(p);
            end
            OP_DEL:
            begin
                if (int'(p) >= list_len)
                    res.st = ST_RANGE;
                else
                begin
                    for (i = int'(p); i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i + 1];
                    list_len--;
                end
            end
            default: ;
        endcase
        // Insert: shift the later entries up by one place.
        if (ins_at >= 0)
        begin
            for (i = list_len; i > ins_at; i--)
                list_mem[i] = list_mem[i - 1];
            list_mem[ins_at] = v;
            list_len++;
        end
        res.cnt = list_len[CNT_W-1:0];
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Offers one word and waits for the edge at which it is taken.
    task automatic send_request(input logic [FUNC_W-1:0] f, input logic [CNT_W-1:0] p,
                                input logic [VAL_W-1:0] v, input logic typed,
                                input list_result_t exp);
        s_tvalid  <= 1'b1;
        s_tdata   <= IN_DW'({v, p, f});
        drv_typed <= typed;
        drv_exp   <= exp;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
    endtask

    // Random gap on the sending side.
    task automatic sender_gap();
        if (tx_idle_en && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    // Holds the sender until every owed result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_results.size() != 0);
    endtask

    // Result side: random stall bursts unless idling is switched off.
    always @(posedge clk)
    begin
        if (!rx_idle_en)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left = $urandom_range(0, 10);
        end
        else
            m_tready <= 1'b1;
    end

    // Checks result words, records accepted requests and runs the watchdog.
    always @(posedge clk)
    begin : observe
        list_result_t want;
        list_result_t got;
        list_result_t calc;
        logic         moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (m_tvalid && m_tready)
            begin
                moved   = 1'b1;
                got.rd  = m_tdata[VAL_W-1:0];
                got.st  = m_tdata[VAL_W+STAT_W-1:VAL_W];
                got.cnt = m_tdata[OUT_BITS-1:VAL_W+STAT_W];
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result word with none expected: expected none, actual %h",
                             $time, m_tdata);
                    errors++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    compare_field("read_value", want.rd, got.rd);
                    compare_field("status", 32'(want.st), 32'(got.st));
                    compare_field("entry_count", 32'(want.cnt), 32'(got.cnt));
                end
            end
            if (s_tvalid && s_tready)
            begin
                moved = 1'b1;
                calc  = apply_list_request(s_tdata[FUNC_W-1:0],
                                           s_tdata[FUNC_W+CNT_W-1:FUNC_W],
                                           s_tdata[IN_BITS-1:FUNC_W+CNT_W]);
                awaited_results.push_back(drv_typed ? drv_exp : calc);
            end
            // Nothing moving on either side for too long means the block hung.
            if (moved)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Stimulus: directed table, then random traffic in fill, empty and mixed phases.
    initial
    begin : stimulus
        int                k;
        int                r;
        int                ins_pct;
        int                del_pct;
        logic [FUNC_W-1:0] f;
        logic [CNT_W-1:0]  p;
        logic [VAL_W-1:0]  v;
        list_result_t      row_exp;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < DIR_ROWS; k++)
        begin
            row_exp.rd  = dir_tab[k].rd;
            row_exp.st  = dir_tab[k].st;
            row_exp.cnt = dir_tab[k].cnt;
            send_request(dir_tab[k].func, dir_tab[k].pos, dir_tab[k].val,
                         dir_tab[k].typed, row_exp);
            sender_gap();
        end
        drain_results();

        for (k = 0; k < RAND_ITEMS; k++)
        begin
            // Idling comes and goes in stretches, and stops for the last part.
            if (k % 50 == 0)
            begin
                tx_idle_en = ($urandom_range(0, 3) != 0);
                rx_idle_en = ($urandom_range(0, 3) != 0);
            end
            if (k >= RAND_ITEMS - QUIET_ITEMS)
            begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            if (k == 200)
                drain_results();

            // First fill the list past full, then empty it, then mix.
            if (k < 130)
            begin
                ins_pct = 85;
                del_pct = 5;
            end
            else if (k < 260)
            begin
                ins_pct = 10;
                del_pct = 75;
            end
            else
            begin
                ins_pct = 40;
                del_pct = 35;
            end

            r = $urandom_range(0, 99);
            if (r < ins_pct)
            begin
                case ($urandom_range(0, 2))
                    0:       f = OP_HEAD;
                    1:       f = OP_TAIL;
                    default: f = OP_AT;
                endcase
            end
            else if (r < ins_pct + del_pct)
                f = OP_DEL;
            else if (r < 97)
                f = OP_READ;
            else
            begin
                case ($urandom_range(0, 2))
                    0:       f = OP_UNUSED_A;
                    1:       f = OP_UNUSED_B;
                    default: f = OP_UNUSED_C;
                endcase
            end

            // Mostly positions that hit the list, sometimes anything at all.
            if ($urandom_range(0, 9) < 8)
            begin
                if (f == OP_AT)
                    p = CNT_W'($urandom_range(0, list_len));
                else if (list_len > 0)
                    p = CNT_W'($urandom_range(0, list_len - 1));
                else
                    p = '0;
            end
            else
                p = CNT_W'($urandom_range(0, 127));

            if ($urandom_range(0, 7) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            else
                v = $urandom;

            send_request(f, p, v, 1'b0, '0);
            sender_gap();
        end

        // Let the last results out, then allow for any straggling word.
        drain_results();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: indexed_list_insert_delete.f
hdl/ili_pkg.sv
hdl/ili_cell.sv
hdl/ili_sel.sv
hdl/indexed_list_insert_delete.sv
dv/tb_indexed_list_insert_delete.sv
